// ===== rtl/upd_pkg.sv =====
// Shared types and constants for the URL percent decoder.
`default_nettype none
package upd_pkg;

	// Default number of run entries between the front and the back.
	localparam int unsigned QUEUE_DEPTH = 4;

	// One run: the zero to three bytes that one input beat produces.
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic       last;
	} run_t;

endpackage
`default_nettype wire

// ===== rtl/upd_front.sv =====
// Front part: tracks escape state and turns each input beat into a run of bytes.
`default_nettype none
module upd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          accept,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	input  wire logic          plus_means_space,
	output upd_pkg::run_t      run,
	output logic               run_push
);

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIGIT
	} phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end
		hex_value = v[3:0];
	endfunction

	phase_t     phase_q;
	logic [7:0] held_q;

	phase_t     phase_d;
	logic [7:0] held_d;
	logic [1:0] pre_cnt;
	logic [7:0] pre0;
	logic [7:0] pre1;
	logic       do_fresh;
	logic       fresh_emit;
	logic [7:0] fresh_byte;
	logic       fresh_opens;
	logic [1:0] total;

	// A byte seen with no escape pending: plus, percent or plain.
	always_comb begin
		fresh_emit  = 1'b1;
		fresh_byte  = in_byte;
		fresh_opens = 1'b0;
		if (in_byte == CHAR_PLUS && plus_means_space) begin
			fresh_byte = CHAR_SPACE;
		end else if (in_byte == CHAR_PCT) begin
			if (!in_last) begin
				fresh_emit  = 1'b0;
				fresh_opens = 1'b1;
			end
		end
	end

	// Escape state: a broken escape flushes its held bytes before the fresh byte.
	always_comb begin
		pre_cnt  = 2'd0;
		pre0     = CHAR_PCT;
		pre1     = held_q;
		do_fresh = 1'b1;
		held_d   = held_q;
		phase_d  = PH_IDLE;
		unique case (phase_q)
			PH_PCT: begin
				if (is_hex(in_byte) && !in_last) begin
					do_fresh = 1'b0;
					held_d   = in_byte;
					phase_d  = PH_DIGIT;
				end else begin
					pre_cnt = 2'd1;
				end
			end
			PH_DIGIT: begin
				if (is_hex(in_byte)) begin
					do_fresh = 1'b0;
					pre_cnt  = 2'd1;
					pre0     = {hex_value(held_q), hex_value(in_byte)};
				end else begin
					pre_cnt = 2'd2;
				end
			end
			default: begin
				pre_cnt = 2'd0;
			end
		endcase
		if (do_fresh && fresh_opens) begin
			phase_d = PH_PCT;
		end
		if (in_last) begin
			phase_d = PH_IDLE;
			held_d  = 8'd0;
		end
	end

	// Pack the prefix bytes and the fresh byte into one run.
	always_comb begin
		total     = pre_cnt + {1'b0, do_fresh & fresh_emit};
		run.count = total;
		run.byte0 = (pre_cnt != 2'd0) ? pre0 : fresh_byte;
		run.byte1 = (pre_cnt == 2'd2) ? pre1 : fresh_byte;
		run.byte2 = fresh_byte;
		run.last  = in_last;
		run_push  = accept && (total != 2'd0);
	end

	// Escape state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

`ifndef SYNTHESIS
	a_last_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (phase_q == PH_IDLE))
		else $error("escape still pending after the last byte of a string");
`endif

endmodule
`default_nettype wire

// ===== rtl/upd_queue.sv =====
// Short queue of runs between the front and the back.
`default_nettype none
module upd_queue #(
	parameter int unsigned Depth = upd_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire upd_pkg::run_t wr_run,
	input  wire logic          pull,
	output upd_pkg::run_t      rd_run,
	output logic               q_full,
	output logic               q_empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	upd_pkg::run_t   slots_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	logic do_push;
	logic do_pull;

	assign q_full  = (count_q == FullCnt);
	assign q_empty = (count_q == '0);
	assign do_push = push && !q_full;
	assign do_pull = pull && !q_empty;
	assign rd_run  = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_run;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pull) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pull) begin
				count_q <= count_q + 1'b1;
			end else if (do_pull && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt)
		else $error("run queue count exceeds its depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/upd_back.sv =====
// Back part: unpacks queued runs into single output beats through an output register.
`default_nettype none
module upd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire upd_pkg::run_t head,
	input  wire logic          head_valid,
	output logic               head_pull,
	input  wire logic          pop,
	output logic               empty,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               string_last
);

	logic [1:0] idx_q;
	logic       valid_q;

	logic       taken;
	logic       load;
	logic       end_of_run;
	logic [7:0] sel_byte;

	assign taken      = pop && valid_q;
	assign load       = head_valid && (!valid_q || taken);
	assign end_of_run = (idx_q == 2'(head.count - 2'd1));
	assign head_pull  = load && end_of_run;
	assign empty      = !valid_q;

	// Pick the byte of the current run at the current position.
	always_comb begin
		unique case (idx_q)
			2'd0:    sel_byte = head.byte0;
			2'd1:    sel_byte = head.byte1;
			default: sel_byte = head.byte2;
		endcase
	end

	// Output register and position within the run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			idx_q       <= 2'd0;
			out_byte    <= 8'd0;
			run_last    <= 1'b0;
			string_last <= 1'b0;
		end else if (load) begin
			valid_q     <= 1'b1;
			out_byte    <= sel_byte;
			run_last    <= end_of_run;
			string_last <= end_of_run && head.last;
			idx_q       <= end_of_run ? 2'd0 : idx_q + 2'd1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head.count))
		else $error("run position beyond the run length");
	a_string_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && string_last) |-> run_last)
		else $error("string end marked on a beat that does not end its run");
`endif

endmodule
`default_nettype wire

// ===== rtl/url_percent_decoder_unit.sv =====
// Top level of the URL percent decoder: front, run queue, back and config register.
//
//  Channel | Handshake        | Payload
//  input   | push / full      | in_byte[7:0], in_last
//  result  | empty / pop      | out_byte[7:0], run_last, string_last
//  config  | cfg_write        | plus_means_space
//
// One input byte is taken per cycle while the run queue has room; the front
// classifies it and queues its run of one to three decoded bytes at once,
// if it has any. The back sends one result beat per cycle while pop takes
// them, so a run of n bytes occupies the output for n beats and the queue
// absorbs the bursts of broken escapes. Results pass the run queue and the
// output register to the ports; full rises when QueueDepth runs are waiting.
// Reset clears the escape state, the queue and the output register.
`default_nettype none
module url_percent_decoder_unit #(
	parameter int unsigned QueueDepth = upd_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic       plus_means_space,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            string_last
);

	logic          plus_q;
	logic          accept;
	upd_pkg::run_t new_run;
	logic          new_push;
	upd_pkg::run_t head_run;
	logic          head_pull;
	logic          q_empty;

	assign accept = push && !full;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q <= 1'b0;
		end else if (cfg_write) begin
			plus_q <= plus_means_space;
		end
	end

	upd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.plus_means_space (plus_q),
		.run              (new_run),
		.run_push         (new_push)
	);

	upd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (new_push),
		.wr_run  (new_run),
		.pull    (head_pull),
		.rd_run  (head_run),
		.q_full  (full),
		.q_empty (q_empty)
	);

	upd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head_run),
		.head_valid  (!q_empty),
		.head_pull   (head_pull),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.string_last (string_last)
	);

endmodule
`default_nettype wire
